FILE: rtl/sm83_alu_with_flags_assert.svh
// Assertion macros shared by the checkers of the SM83 ALU block.
`ifndef SM83_ALU_WITH_FLAGS_ASSERT_SVH
`define SM83_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SM83_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SM83_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle that follows a cycle with reset asserted.
`define SM83_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sm83alu_pkg.sv
// Shared types, operation codes and constants of the SM83 ALU block.
package sm83alu_pkg;

    // Operation codes carried in the action field.
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBC  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_OR   = 5'd6;
    localparam logic [4:0] OP_CP   = 5'd7;
    localparam logic [4:0] OP_INC  = 5'd8;
    localparam logic [4:0] OP_DEC  = 5'd9;
    localparam logic [4:0] OP_DAA  = 5'd10;
    localparam logic [4:0] OP_CPL  = 5'd11;
    localparam logic [4:0] OP_SCF  = 5'd12;
    localparam logic [4:0] OP_CCF  = 5'd13;
    localparam logic [4:0] OP_RLC  = 5'd14;
    localparam logic [4:0] OP_RRC  = 5'd15;
    localparam logic [4:0] OP_RL   = 5'd16;
    localparam logic [4:0] OP_RR   = 5'd17;
    localparam logic [4:0] OP_SLA  = 5'd18;
    localparam logic [4:0] OP_SRA  = 5'd19;
    localparam logic [4:0] OP_SWAP = 5'd20;
    localparam logic [4:0] OP_SRL  = 5'd21;
    localparam logic [4:0] OP_BIT  = 5'd22;
    localparam logic [4:0] OP_RES  = 5'd23;
    localparam logic [4:0] OP_SET  = 5'd24;
    localparam logic [4:0] OP_ADDW = 5'd25;
    localparam logic [4:0] OP_ADSP = 5'd26;
    localparam logic [4:0] OP_RLCA = 5'd27;
    localparam logic [4:0] OP_RRCA = 5'd28;
    localparam logic [4:0] OP_RLA  = 5'd29;
    localparam logic [4:0] OP_RRA  = 5'd30;

    // Bit positions inside the packed flag nibble.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants.
    localparam logic [7:0] BCD_MAX = 8'h99;
    localparam logic [7:0] DAA_HI  = 8'h60;
    localparam logic [7:0] DAA_LO  = 8'h06;
    localparam logic [3:0] BCD_DIG = 4'h9;

    // Stream widths, padded to whole bytes.
    localparam int unsigned IN_BITS  = 72;
    localparam int unsigned OUT_BITS = 32;

    // One request as the ALU sees it.
    typedef struct packed {
        logic [4:0]        action;
        logic [7:0]        acc;
        logic [7:0]        operand;
        logic [3:0]        flags_in;
        logic [2:0]        bit_index;
        logic [15:0]       wide_left;
        logic [15:0]       wide_right;
        logic signed [7:0] offset;
    } t_alu_req;

    // One result of the ALU.
    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [3:0]  flags_out;
    } t_alu_rsp;

endpackage

FILE: rtl/sm83_alu_with_flags.sv
// Top level of the SM83 ALU block: stream ports, request and result registers.
//
// Each request passes through an input register, one level of ALU logic
// and a result register. A request that is taken is loaded into the input
// register, and its result is loaded into the result register when that
// register frees up, and is offered from there to the result side. One request
// is accepted in every cycle while results are taken. The block holds up to
// two requests in flight. When the result side stalls, it keeps taking
// requests until both registers are full.
module sm83_alu_with_flags (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: action[5], acc[8], operand[8], flags_in[4], bit_index[3],
    // wide_left[16], wide_right[16], offset[8], zero padding[4].
    input  logic [sm83alu_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0: result_byte[8], result_word[16], flags_out[4], zero padding[4].
    output logic [sm83alu_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import sm83alu_pkg::*;

    logic     r_in_valid;
    t_alu_req r_in;
    logic     r_out_valid;
    t_alu_rsp r_out;
    t_alu_req req_unpack;
    t_alu_rsp alu_rsp;
    logic     out_free;
    logic     in_take;

    // Unpack the request fields from the stream word.
    assign req_unpack.action     = s_axis_tdata[4:0];
    assign req_unpack.acc        = s_axis_tdata[12:5];
    assign req_unpack.operand    = s_axis_tdata[20:13];
    assign req_unpack.flags_in   = s_axis_tdata[24:21];
    assign req_unpack.bit_index  = s_axis_tdata[27:25];
    assign req_unpack.wide_left  = s_axis_tdata[43:28];
    assign req_unpack.wide_right = s_axis_tdata[59:44];
    assign req_unpack.offset     = s_axis_tdata[67:60];

    // The result register frees up when empty or when its result is taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_take) begin
            r_in <= req_unpack;
        end
    end

    sm83alu_core u_core (
        .i_req (r_in),
        .o_rsp (alu_rsp)
    );

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (out_free && r_in_valid) begin
            r_out <= alu_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.flags_out, r_out.result_word, r_out.result_byte};

endmodule

FILE: rtl/sm83alu_core.sv
// Combinational datapath of the SM83 ALU: 8-bit, 16-bit and flag results.
module sm83alu_core (
    input  sm83alu_pkg::t_alu_req i_req,
    output sm83alu_pkg::t_alu_rsp o_rsp
);
    import sm83alu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  f;
    logic        cin;
    logic        t_add;
    logic        t_sub;
    logic [8:0]  sum9;
    logic [4:0]  sum_lo;
    logic [8:0]  dif9;
    logic [4:0]  dif_lo;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic        daa_c;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_r;
    logic [7:0]  rot_src;
    logic [7:0]  bit_mask;
    logic [16:0] hl_sum;
    logic [12:0] hl_lo;
    logic [15:0] off16;
    logic [15:0] sp_sum;
    logic [15:0] sp_cry;
    logic [7:0]  rb;
    logic [15:0] rw;
    logic [3:0]  fo;

    assign a   = i_req.acc;
    assign v   = i_req.operand;
    assign f   = i_req.flags_in;
    assign cin = f[FLAG_C];

    // Adder and subtractor with nibble carries for the accumulator group.
    assign t_add  = (i_req.action == OP_ADC) & cin;
    assign t_sub  = (i_req.action == OP_SBC) & cin;
    assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, t_add};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t_add};
    assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, t_sub};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t_sub};
    assign inc8   = v + 8'd1;
    assign dec8   = v - 8'd1;

    // Decimal adjust after an add (N clear) or a subtract (N set).
    always_comb begin
        if (!f[FLAG_N]) begin
            daa_c   = cin | (a > BCD_MAX);
            daa_adj = (daa_c ? DAA_HI : 8'd0)
                    | ((f[FLAG_H] | (a[3:0] > BCD_DIG)) ? DAA_LO : 8'd0);
            daa_r   = a + daa_adj;
        end else begin
            daa_c   = cin;
            daa_adj = (cin ? DAA_HI : 8'd0) | (f[FLAG_H] ? DAA_LO : 8'd0);
            daa_r   = a - daa_adj;
        end
    end

    // The accumulator rotates work on A, the prefixed ones on the operand.
    assign rot_src  = (i_req.action >= OP_RLCA) ? a : v;
    assign bit_mask = 8'd1 << i_req.bit_index;

    // 16-bit adds: HL plus a pair, and SP plus a sign-extended offset.
    assign hl_sum = {1'b0, i_req.wide_left} + {1'b0, i_req.wide_right};
    assign hl_lo  = {1'b0, i_req.wide_left[11:0]} + {1'b0, i_req.wide_right[11:0]};
    assign off16  = {{8{i_req.offset[7]}}, i_req.offset};
    assign sp_sum = i_req.wide_left + off16;
    assign sp_cry = i_req.wide_left ^ off16 ^ sp_sum;

    // Result and flag selection.
    always_comb begin
        rb = a;
        rw = 16'd0;
        fo = f;
        case (i_req.action)
            OP_ADD, OP_ADC: begin
                rb = sum9[7:0];
                fo = {sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                rb = (i_req.action == OP_CP) ? a : dif9[7:0];
                fo = {dif9[7:0] == 8'd0, 1'b1, dif_lo[4], dif9[8]};
            end
            OP_AND: begin
                rb = a & v;
                fo = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                rb = a ^ v;
                fo = {(a ^ v) == 8'd0, 3'b000};
            end
            OP_OR: begin
                rb = a | v;
                fo = {(a | v) == 8'd0, 3'b000};
            end
            OP_INC: begin
                rb = inc8;
                fo = {inc8 == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
            end
            OP_DEC: begin
                rb = dec8;
                fo = {dec8 == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
            end
            OP_DAA: begin
                rb = daa_r;
                fo = {daa_r == 8'd0, f[FLAG_N], 1'b0, daa_c};
            end
            OP_CPL: begin
                rb = ~a;
                fo = {f[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF: fo = {f[FLAG_Z], 3'b001};
            OP_CCF: fo = {f[FLAG_Z], 2'b00, ~cin};
            OP_RLC, OP_RLCA: begin
                rb = {rot_src[6:0], rot_src[7]};
                fo = {(i_req.action == OP_RLC) && (rot_src == 8'd0), 2'b00, rot_src[7]};
            end
            OP_RRC, OP_RRCA: begin
                rb = {rot_src[0], rot_src[7:1]};
                fo = {(i_req.action == OP_RRC) && (rot_src == 8'd0), 2'b00, rot_src[0]};
            end
            OP_RL, OP_RLA: begin
                rb = {rot_src[6:0], cin};
                fo = {(i_req.action == OP_RL) && ({rot_src[6:0], cin} == 8'd0),
                      2'b00, rot_src[7]};
            end
            OP_RR, OP_RRA: begin
                rb = {cin, rot_src[7:1]};
                fo = {(i_req.action == OP_RR) && ({cin, rot_src[7:1]} == 8'd0),
                      2'b00, rot_src[0]};
            end
            OP_SLA: begin
                rb = {v[6:0], 1'b0};
                fo = {v[6:0] == 7'd0, 2'b00, v[7]};
            end
            OP_SRA: begin
                rb = {v[7], v[7:1]};
                fo = {v[7:1] == 7'd0, 2'b00, v[0]};
            end
            OP_SWAP: begin
                rb = {v[3:0], v[7:4]};
                fo = {v == 8'd0, 3'b000};
            end
            OP_SRL: begin
                rb = {1'b0, v[7:1]};
                fo = {v[7:1] == 7'd0, 2'b00, v[0]};
            end
            OP_BIT: begin
                rb = v;
                fo = {(v & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
            end
            OP_RES: rb = v & ~bit_mask;
            OP_SET: rb = v | bit_mask;
            OP_ADDW: begin
                rw = hl_sum[15:0];
                fo = {f[FLAG_Z], 1'b0, hl_lo[12], hl_sum[16]};
            end
            OP_ADSP: begin
                rw = sp_sum;
                fo = {2'b00, sp_cry[4], sp_cry[8]};
            end
            default: begin
                rb = a;
                rw = 16'd0;
                fo = f;
            end
        endcase
    end

    assign o_rsp.result_byte = rb;
    assign o_rsp.result_word = rw;
    assign o_rsp.flags_out   = fo;

endmodule

FILE: rtl/sm83alu_chk.sv
// Port-level checker of the SM83 ALU block and its bind to the top level.
`include "sm83_alu_with_flags_assert.svh"

module sm83alu_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sm83alu_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import sm83alu_pkg::*;

    // A stalled result keeps its data.
    `SM83_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // With no result waiting, the request side is always open.
    `SM83_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "requests blocked with empty result stage")

    // The padding above the flags is always zero.
    `SM83_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_BITS-1:28] == 4'd0, "result padding not zero")

    // Reset empties the result stage.
    `SM83_ASSERT_RST(a_rst_empty, !m_axis_tvalid, "result valid right after reset")

endmodule

bind sm83_alu_with_flags sm83alu_chk u_sm83alu_chk (.*);

FILE: tb/testbench.sv
// Self-checking bench for the SM83 ALU: predicts each result and compares it in order.
module testbench;
    import sm83alu_pkg::*;

    // Action code that leaves everything as it was.
    localparam logic [4:0] OP_NOP = 5'd31;

    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned LONG_HOLD    = 40;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned IDLE_LIMIT   = 400;
    localparam int unsigned CHUNKS       = 7;
    localparam int unsigned CHUNK_ITEMS  = 100;
    localparam int unsigned MAX_REPORTS  = 10;

    // Entries of the stimulus plan: requests and pacing marks.
    typedef enum logic [2:0] {
        PLAN_REQ,
        PLAN_DRAIN,
        PLAN_STALL,
        PLAN_BRISK_ON,
        PLAN_BRISK_OFF
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind kind;
        t_alu_req   req;
    } t_plan_entry;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // From bit 0: action, acc, operand, flags_in, bit_index, wide_left, wide_right,
    // offset, zero padding.
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // From bit 0: result_byte, result_word, flags_out, zero padding.
    logic [OUT_BITS-1:0] m_axis_tdata;

    t_plan_entry request_plan [$];
    t_alu_rsp    awaited_results [$];
    t_alu_req    offered_req = '0;

    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    logic        brisk    = 1'b0;
    logic        tx_draining = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned rx_hold = 0;
    int unsigned stall_requests = 0;
    int unsigned stall_served = 0;
    int unsigned stuck_cycles = 0;
    int unsigned request_total = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;

    sm83_alu_with_flags u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock, period of two units.
    always #1 i_clk = ~i_clk;

    // Packs the four flags into the Z N H C nibble.
    function automatic logic [3:0] flag_nibble(input logic z, input logic n,
                                               input logic h, input logic c);
        logic [3:0] nib;
        nib = '0;
        nib[FLAG_Z] = z;
        nib[FLAG_N] = n;
        nib[FLAG_H] = h;
        nib[FLAG_C] = c;
        return nib;
    endfunction

    // Computes the byte, word and flags that one request must produce.
    function automatic t_alu_rsp predict_alu(input t_alu_req q);
        t_alu_rsp    p;
        logic        cy;
        logic        t;
        logic        dc;
        logic [7:0]  src;
        logic [7:0]  d;
        logic [7:0]  mask;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [15:0] ext;
        logic [15:0] mix;
        p.result_byte = q.acc;
        p.result_word = '0;
        p.flags_out   = q.flags_in;
        cy   = q.flags_in[FLAG_C];
        src  = (q.action >= OP_RLCA) ? q.acc : q.operand;
        mask = 8'd1 << q.bit_index;
        case (q.action)
            OP_ADD, OP_ADC: begin
                t  = (q.action == OP_ADC) && cy;
                s9 = {1'b0, q.acc} + {1'b0, q.operand} + {8'd0, t};
                s5 = {1'b0, q.acc[3:0]} + {1'b0, q.operand[3:0]} + {4'd0, t};
                p.result_byte = s9[7:0];
                p.flags_out = flag_nibble(s9[7:0] == 8'd0, 1'b0, s5[4], s9[8]);
            end
            OP_SUB, OP_SBC, OP_CP: begin
                // Bit 8 and bit 4 of the differences are the full and half borrows.
                t  = (q.action == OP_SBC) && cy;
                s9 = {1'b0, q.acc} - {1'b0, q.operand} - {8'd0, t};
                s5 = {1'b0, q.acc[3:0]} - {1'b0, q.operand[3:0]} - {4'd0, t};
                p.result_byte = (q.action == OP_CP) ? q.acc : s9[7:0];
                p.flags_out = flag_nibble(s9[7:0] == 8'd0, 1'b1, s5[4], s9[8]);
            end
            OP_AND: begin
                p.result_byte = q.acc & q.operand;
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR: begin
                p.result_byte = q.acc ^ q.operand;
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            OP_OR: begin
                p.result_byte = q.acc | q.operand;
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            OP_INC: begin
                p.result_byte = q.operand + 8'd1;
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0,
                                          q.operand[3:0] == 4'hF, cy);
            end
            OP_DEC: begin
                p.result_byte = q.operand - 8'd1;
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b1,
                                          q.operand[3:0] == 4'h0, cy);
            end
            OP_DAA: begin
                // After an addition correct upward, after a subtraction downward.
                d  = q.acc;
                dc = cy;
                if (!q.flags_in[FLAG_N]) begin
                    if (cy || q.acc > BCD_MAX) begin
                        d  = d + DAA_HI;
                        dc = 1'b1;
                    end
                    if (q.flags_in[FLAG_H] || d[3:0] > BCD_DIG) d = d + DAA_LO;
                end else begin
                    if (cy) d = d - DAA_HI;
                    if (q.flags_in[FLAG_H]) d = d - DAA_LO;
                end
                p.result_byte = d;
                p.flags_out = flag_nibble(d == 8'd0, q.flags_in[FLAG_N], 1'b0, dc);
            end
            OP_CPL: begin
                p.result_byte = ~q.acc;
                p.flags_out = flag_nibble(q.flags_in[FLAG_Z], 1'b1, 1'b1, cy);
            end
            OP_SCF: p.flags_out = flag_nibble(q.flags_in[FLAG_Z], 1'b0, 1'b0, 1'b1);
            OP_CCF: p.flags_out = flag_nibble(q.flags_in[FLAG_Z], 1'b0, 1'b0, !cy);
            // The accumulator rotates always clear Z.
            OP_RLC, OP_RLCA: begin
                p.result_byte = {src[6:0], src[7]};
                p.flags_out = flag_nibble(q.action == OP_RLC && p.result_byte == 8'd0,
                                          1'b0, 1'b0, src[7]);
            end
            OP_RRC, OP_RRCA: begin
                p.result_byte = {src[0], src[7:1]};
                p.flags_out = flag_nibble(q.action == OP_RRC && p.result_byte == 8'd0,
                                          1'b0, 1'b0, src[0]);
            end
            OP_RL, OP_RLA: begin
                p.result_byte = {src[6:0], cy};
                p.flags_out = flag_nibble(q.action == OP_RL && p.result_byte == 8'd0,
                                          1'b0, 1'b0, src[7]);
            end
            OP_RR, OP_RRA: begin
                p.result_byte = {cy, src[7:1]};
                p.flags_out = flag_nibble(q.action == OP_RR && p.result_byte == 8'd0,
                                          1'b0, 1'b0, src[0]);
            end
            OP_SLA: begin
                p.result_byte = {q.operand[6:0], 1'b0};
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, q.operand[7]);
            end
            OP_SRA: begin
                p.result_byte = {q.operand[7], q.operand[7:1]};
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, q.operand[0]);
            end
            OP_SWAP: begin
                p.result_byte = {q.operand[3:0], q.operand[7:4]};
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            OP_SRL: begin
                p.result_byte = {1'b0, q.operand[7:1]};
                p.flags_out = flag_nibble(p.result_byte == 8'd0, 1'b0, 1'b0, q.operand[0]);
            end
            OP_BIT: begin
                p.result_byte = q.operand;
                p.flags_out = flag_nibble((q.operand & mask) == 8'd0, 1'b0, 1'b1, cy);
            end
            OP_RES: p.result_byte = q.operand & ~mask;
            OP_SET: p.result_byte = q.operand | mask;
            OP_ADDW: begin
                // Half carry comes out of bit 11, carry out of bit 15; Z is kept.
                s17 = {1'b0, q.wide_left} + {1'b0, q.wide_right};
                s13 = {1'b0, q.wide_left[11:0]} + {1'b0, q.wide_right[11:0]};
                p.result_word = s17[15:0];
                p.flags_out = flag_nibble(q.flags_in[FLAG_Z], 1'b0, s13[12], s17[16]);
            end
            OP_ADSP: begin
                // Flags come from the low byte: carries out of bits 3 and 7.
                ext = {{8{q.offset[7]}}, q.offset};
                p.result_word = q.wide_left + ext;
                mix = q.wide_left ^ ext ^ p.result_word;
                p.flags_out = flag_nibble(1'b0, 1'b0, mix[4], mix[8]);
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic int unsigned draw_gap();
        return brisk ? 0 : $urandom_range(0, 3);
    endfunction

    // Random byte with a bias toward the carry and BCD boundaries.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'h80;
            4: return 8'h99;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_alu_req random_req(input logic [4:0] op);
        t_alu_req q;
        q.action     = op;
        q.acc        = pick_byte();
        q.operand    = pick_byte();
        q.flags_in   = 4'($urandom_range(0, 15));
        q.bit_index  = 3'($urandom_range(0, 7));
        q.wide_left  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        q.wide_right = ($urandom_range(0, 7) == 0) ? 16'h0FFF : 16'($urandom_range(0, 65535));
        q.offset     = pick_byte();
        return q;
    endfunction

    task automatic queue_request(input t_alu_req q);
        t_plan_entry e;
        e.kind = PLAN_REQ;
        e.req  = q;
        request_plan.push_back(e);
        request_total++;
    endtask

    task automatic queue_mark(input t_plan_kind kind);
        t_plan_entry e;
        e.kind = kind;
        e.req  = '0;
        request_plan.push_back(e);
    endtask

    task automatic add_dir(input logic [4:0] op, input logic [7:0] a, input logic [7:0] v,
                           input logic [3:0] f, input logic [2:0] bi, input logic [15:0] wl,
                           input logic [15:0] wr, input logic [7:0] off);
        t_alu_req q;
        q.action     = op;
        q.acc        = a;
        q.operand    = v;
        q.flags_in   = f;
        q.bit_index  = bi;
        q.wide_left  = wl;
        q.wide_right = wr;
        q.offset     = off;
        queue_request(q);
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Sender: offers the next planned request once the previous one is taken and its gap is over.
    always @(negedge i_clk) begin : drive_proc
        t_plan_entry e;
        logic        offer;
        logic [IN_BITS-1:0] data;
        t_alu_req    req;
        offer = s_axis_tvalid && !in_fire;
        data  = s_axis_tdata;
        req   = offered_req;
        if (!offer && i_rst_n) begin
            if (tx_gap != 0) begin
                tx_gap--;
            end else if (tx_draining) begin
                if (awaited_results.size() == 0) tx_draining = 1'b0;
            end else if (request_plan.size() != 0) begin
                e = request_plan.pop_front();
                case (e.kind)
                    PLAN_REQ: begin
                        offer  = 1'b1;
                        req    = e.req;
                        data   = {4'b0, e.req.offset, e.req.wide_right, e.req.wide_left,
                                  e.req.bit_index, e.req.flags_in, e.req.operand,
                                  e.req.acc, e.req.action};
                        tx_gap = draw_gap();
                    end
                    PLAN_DRAIN:     tx_draining = 1'b1;
                    PLAN_STALL:     stall_requests <= stall_requests + 1;
                    PLAN_BRISK_ON:  brisk <= 1'b1;
                    PLAN_BRISK_OFF: brisk <= 1'b0;
                    default: ;
                endcase
            end
        end
        s_axis_tvalid <= offer;
        s_axis_tdata  <= data;
        offered_req   <= req;
    end

    // Receiver: a random gap after each result, and a long hold when the sender asks for one.
    always @(negedge i_clk) begin : receive_proc
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            rx_hold      = LONG_HOLD;
        end
        if (out_fire) rx_gap = draw_gap();
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest prediction, then records new requests.
    always @(posedge i_clk) begin : monitor_proc
        t_alu_rsp got;
        t_alu_rsp want;
        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result_byte = m_axis_tdata[7:0];
            got.result_word = m_axis_tdata[23:8];
            got.flags_out   = m_axis_tdata[27:24];
            if (awaited_results.size() == 0) begin
                flag_error($sformatf("Unexpected result %h with nothing outstanding",
                                     m_axis_tdata));
            end else begin
                want = awaited_results.pop_front();
                if (got.result_byte !== want.result_byte)
                    flag_error($sformatf("Result %0d: result_byte expected %02h, got %02h",
                                         results_checked, want.result_byte, got.result_byte));
                if (got.result_word !== want.result_word)
                    flag_error($sformatf("Result %0d: result_word expected %04h, got %04h",
                                         results_checked, want.result_word, got.result_word));
                if (got.flags_out !== want.flags_out)
                    flag_error($sformatf("Result %0d: flags_out expected %04b, got %04b",
                                         results_checked, want.flags_out, got.flags_out));
                results_checked++;
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            awaited_results.push_back(predict_alu(offered_req));
            requests_taken++;
        end
    end

    // Watchdog on cycles in which no request moves on either side.
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == IDLE_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Builds the plan, releases reset and waits for the last result.
    initial begin : stimulus_proc
        int unsigned c;
        int unsigned k;

        // Directed requests: one or more corner cases for every action code.
        add_dir(OP_ADD,  8'h0F, 8'h01, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_ADD,  8'hFF, 8'h01, 4'b1111, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_dir(OP_ADC,  8'hFF, 8'h00, 4'b0001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SUB,  8'h3E, 8'h3E, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SBC,  8'h00, 8'h00, 4'b0001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_AND,  8'hF0, 8'h0F, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_XOR,  8'hFF, 8'hFF, 4'b0111, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_OR,   8'h00, 8'h00, 4'b0111, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_CP,   8'h10, 8'h01, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_INC,  8'h00, 8'hFF, 4'b0001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_DEC,  8'h00, 8'h10, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_DAA,  8'h9A, 8'h00, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_DAA,  8'h0F, 8'h00, 4'b0111, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_CPL,  8'h00, 8'h00, 4'b1001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SCF,  8'h5A, 8'h00, 4'b0110, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_CCF,  8'hA5, 8'h00, 4'b1001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RLC,  8'h00, 8'h80, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RRC,  8'h00, 8'h01, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RL,   8'h00, 8'h80, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RR,   8'h00, 8'h01, 4'b0001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SLA,  8'h00, 8'h80, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SRA,  8'h00, 8'h81, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SWAP, 8'h00, 8'h00, 4'b0111, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SRL,  8'h00, 8'h01, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_BIT,  8'h00, 8'h7F, 4'b0001, 3'd7, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RES,  8'h00, 8'hFF, 4'b1010, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_SET,  8'h00, 8'h00, 4'b1111, 3'd7, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_ADDW, 8'h00, 8'h00, 4'b1000, 3'd0, 16'h8FFF, 16'h8001, 8'h00);
        add_dir(OP_ADSP, 8'h00, 8'h00, 4'b1111, 3'd0, 16'h0000, 16'h0000, 8'h80);
        add_dir(OP_ADSP, 8'h00, 8'h00, 4'b0000, 3'd0, 16'hFFFF, 16'h0000, 8'h7F);
        add_dir(OP_RLCA, 8'h00, 8'h00, 4'b1000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RRCA, 8'h01, 8'h00, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RLA,  8'h80, 8'h00, 4'b1000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_RRA,  8'h01, 8'h00, 4'b0001, 3'd0, 16'h0000, 16'h0000, 8'h00);
        add_dir(OP_NOP,  8'hFF, 8'hFF, 4'b1111, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_dir(OP_NOP,  8'h00, 8'h00, 4'b0000, 3'd0, 16'h0000, 16'h0000, 8'h00);
        queue_mark(PLAN_DRAIN);

        // Random requests in chunks with different pacing.
        for (c = 0; c < CHUNKS; c++) begin
            if (c == 1) queue_mark(PLAN_BRISK_ON);
            if (c == 2) queue_mark(PLAN_BRISK_OFF);
            if (c == 3 || c == 6) queue_mark(PLAN_STALL);
            for (k = 0; k < CHUNK_ITEMS; k++) begin
                if (c == 5 && k == CHUNK_ITEMS / 2) queue_mark(PLAN_DRAIN);
                queue_request(random_req(5'($urandom_range(0, 31))));
            end
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken != request_total || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests over all 32 action codes; %0d results compared.",
                 requests_taken, results_checked);
        $display("Pacing included bursts, random gaps, long output holds and full drains.");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches found", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
